// File: rtl/tsar_pkg.sv
// ----------------------------------------------------------------------------
// tsar_pkg: shared types and constants for the tire slip angle and ratio block
// Transaction structs, CORDIC angle table and fixed-point widths.
// ----------------------------------------------------------------------------
package tsar_pkg;

	typedef struct packed {
		logic signed [15:0] side_slip;
		logic signed [15:0] yaw_rate;
		logic signed [15:0] body_speed;
		logic signed [15:0] steer_angle;
		logic signed [15:0] front_wheel_speed;
		logic signed [15:0] rear_wheel_speed;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] front_slip_angle;
		logic signed [15:0] rear_slip_angle;
		logic signed [15:0] front_slip_ratio;
		logic signed [15:0] rear_slip_ratio;
	} result_t;

	// Configuration register indexes and reset values.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_FRONT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REAR = 1'b1;
	localparam logic [CFG_W-1:0] FRONT_RESET = 16'd4915;
	localparam logic [CFG_W-1:0] REAR_RESET = 16'd6144;

	// At or below this speed (Q8.8, 1 m/s) every result field is zero.
	localparam logic signed [15:0] LOW_SPEED = 16'sd256;

	// CORDIC angle table, atan(2^-i) at scale 2^20.
	localparam int TABLE_LEN = 24;
	localparam logic [19:0] ATAN_TABLE [TABLE_LEN] = '{
		20'd823550, 20'd486170, 20'd256879, 20'd130396, 20'd65451, 20'd32757,
		20'd16383, 20'd8192, 20'd4096, 20'd2048, 20'd1024, 20'd512,
		20'd256, 20'd128, 20'd64, 20'd32, 20'd16, 20'd8,
		20'd4, 20'd2, 20'd1, 20'd0, 20'd0, 20'd0
	};

	// Datapath widths.
	localparam int AXW = 40;	// vectoring rotator x and y, scale 2^24
	localparam int ZW = 24;		// accumulated arctangent, scale 2^20
	localparam int ACW = 26;	// sine/cosine rotator angle, scale 2^20
	localparam int SCW = 28;	// cosine and sine, scale 2^24
	localparam int SPLIT = 14;	// low part of the sine in the split product
	localparam int TW = 27;		// angle before rounding to Q3.12

	localparam logic signed [ACW-1:0] ANG_PI = 26'sd3294199;
	localparam logic signed [ACW-1:0] ANG_TWO_PI = 26'sd6588397;
	localparam logic signed [ACW-1:0] ANG_HALF_PI = 26'sd1647099;
	localparam logic signed [SCW-1:0] GAIN_INV = 28'sd10188014;

	// Restoring divider: 17 quotient bits, one per stage.
	localparam int DIV_NW = 28;
	localparam int DIV_DW = 27;
	localparam int DIV_QW = 17;
	localparam int DIV_REM_W = DIV_DW + DIV_QW;
	localparam int DIV_LAT = DIV_QW + 2;

	// Latency from accept to result, not counting the CORDIC stages.
	localparam int LAT_FIXED = DIV_LAT + 7;

	function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
		logic signed [15:0] r;
		if (v > 24'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -24'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/tsar_div.sv
// ----------------------------------------------------------------------------
// tsar_div: pipelined Q3.12 ratio divider
// Computes (num * 4096) / den truncated toward zero, saturated to 16 bits,
// with one restoring step per stage.
// ----------------------------------------------------------------------------
module tsar_div
	import tsar_pkg::*;
(
	input  logic                     clk,
	input  logic signed [DIV_NW-1:0] num,
	input  logic signed [DIV_DW-1:0] den,
	output logic signed [15:0]       ratio
);

	logic [DIV_REM_W-1:0] rem_s [0:DIV_QW];
	logic [DIV_DW-1:0]    dv_s  [0:DIV_QW];
	logic [DIV_QW-1:0]    q_s   [0:DIV_QW];
	logic                 neg_s [0:DIV_QW];
	logic                 zero_s[0:DIV_QW];
	logic                 ovf_s [0:DIV_QW];

	logic [DIV_NW-1:0] num_abs;
	logic [DIV_DW-1:0] den_abs;

	assign num_abs = num[DIV_NW-1] ? DIV_NW'(-num) : DIV_NW'(num);
	assign den_abs = den[DIV_DW-1] ? DIV_DW'(-den) : DIV_DW'(den);

	always_ff @(posedge clk) begin
		rem_s[0]  <= DIV_REM_W'({num_abs, 12'b0});
		dv_s[0]   <= den_abs;
		q_s[0]    <= '0;
		neg_s[0]  <= num[DIV_NW-1] ^ den[DIV_DW-1];
		zero_s[0] <= (num == '0);
		ovf_s[0]  <= 1'b0;
	end

	for (genvar j = 0; j < DIV_QW; j++) begin : g_step
		localparam int K = DIV_QW - 1 - j;
		logic [DIV_REM_W-1:0] sub;
		logic                 ge;
		assign sub = DIV_REM_W'(dv_s[j]) << K;
		assign ge = (rem_s[j] >= sub);

		always_ff @(posedge clk) begin
			rem_s[j+1]  <= ge ? rem_s[j] - sub : rem_s[j];
			q_s[j+1]    <= {q_s[j][DIV_QW-2:0], ge};
			dv_s[j+1]   <= dv_s[j];
			neg_s[j+1]  <= neg_s[j];
			zero_s[j+1] <= zero_s[j];
			// The quotient needs more than DIV_QW bits (or the divisor is zero).
			if (j == 0) begin
				ovf_s[j+1] <= (rem_s[j] >= (DIV_REM_W'(dv_s[j]) << DIV_QW));
			end else begin
				ovf_s[j+1] <= ovf_s[j];
			end
		end
	end

	logic signed [DIV_QW:0] q_signed;
	assign q_signed = neg_s[DIV_QW] ? -$signed({1'b0, q_s[DIV_QW]})
		: $signed({1'b0, q_s[DIV_QW]});

	always_ff @(posedge clk) begin
		if (zero_s[DIV_QW]) begin
			ratio <= '0;
		end else if (ovf_s[DIV_QW]) begin
			ratio <= neg_s[DIV_QW] ? 16'sh8000 : 16'sh7FFF;
		end else begin
			ratio <= sat16(24'(q_signed));
		end
	end

endmodule

// File: rtl/tire_slip_angle_and_ratio.sv
// ----------------------------------------------------------------------------
// tire_slip_angle_and_ratio: bicycle-model tire slip angles and slip ratios
// Front and rear lateral slip angles from CORDIC arctangents, front and rear
// longitudinal slip ratios from pipelined dividers.
// ----------------------------------------------------------------------------
// Usage:
// A sample is taken at a rising edge with start high and busy low. busy is
// high only while reset is asserted, so one sample can enter every cycle.
// Each sample produces one transaction on result, marked by done for exactly
// one cycle. Its depth: the input and setup registers, the CORDIC rotators
// (one stage per iteration), four stages forming the front axle speed and
// divider operands, a 19-stage divider whose step stages each resolve one
// quotient bit, and the output register. Throughput is one sample per cycle,
// and results leave in the order the samples came. The axle distances are
// written through cfg_we, cfg_index and cfg_data; the user must write them
// only while no transaction is in flight, which the block does not enforce.
// Reset restores the default distances and empties the pipeline; samples in
// flight are dropped. The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module tire_slip_angle_and_ratio
	import tsar_pkg::*;
#(
	parameter int CORDIC_STAGES = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  sample_t              sample,
	output logic                 done,
	output result_t              result
);

	typedef struct packed {
		logic               low;
		logic               flip;
		logic signed [15:0] steer;
		logic signed [15:0] speed;
		logic signed [15:0] wf;
		logic signed [15:0] wr;
		logic signed [32:0] ayaw;
	} side_t;

	localparam int N = CORDIC_STAGES;

	logic [CFG_W-1:0] front_q;
	logic [CFG_W-1:0] rear_q;

	assign busy = ~arst_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= FRONT_RESET;
			rear_q <= REAR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRONT: front_q <= cfg_data;
				CFG_REAR: rear_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	logic    val_s1;
	sample_t smp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
		end else begin
			val_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		smp_s1 <= sample;
	end

	// Operand setup for the rotators.
	logic signed [32:0]    ayaw_c, byaw_c;
	logic signed [31:0]    bv_c;
	logic signed [35:0]    base_c;
	logic signed [AXW-1:0] vx_c, yf_c, yr_c;
	logic signed [ACW-1:0] a0_c, a1_c, a2_c;
	logic                  flip_c;
	side_t                 side_c;

	always_comb begin
		ayaw_c = $signed({1'b0, front_q}) * smp_s1.yaw_rate;
		byaw_c = $signed({1'b0, rear_q}) * smp_s1.yaw_rate;
		bv_c = smp_s1.side_slip * smp_s1.body_speed;
		base_c = $signed({bv_c, 4'b0});
		vx_c = AXW'(smp_s1.body_speed) <<< 16;
		yf_c = AXW'(base_c) + AXW'(ayaw_c);
		yr_c = AXW'(base_c) - AXW'(byaw_c);

		// Reduce the steer angle into [-pi/2, pi/2], flipping signs past pi/2.
		a0_c = ACW'(smp_s1.steer_angle) <<< 8;
		if (a0_c > ANG_PI) begin
			a1_c = a0_c - ANG_TWO_PI;
		end else if (a0_c < -ANG_PI) begin
			a1_c = a0_c + ANG_TWO_PI;
		end else begin
			a1_c = a0_c;
		end
		a2_c = a1_c;
		flip_c = 1'b0;
		if (a1_c > ANG_HALF_PI) begin
			a2_c = a1_c - ANG_PI;
			flip_c = 1'b1;
		end else if (a1_c < -ANG_HALF_PI) begin
			a2_c = a1_c + ANG_PI;
			flip_c = 1'b1;
		end

		side_c.low = !(smp_s1.body_speed > LOW_SPEED);
		side_c.flip = flip_c;
		side_c.steer = smp_s1.steer_angle;
		side_c.speed = smp_s1.body_speed;
		side_c.wf = smp_s1.front_wheel_speed;
		side_c.wr = smp_s1.rear_wheel_speed;
		side_c.ayaw = ayaw_c;
	end

	// CORDIC pipelines: front and rear vectoring, steer sine/cosine rotation.
	logic                  val_s [0:N];
	logic signed [AXW-1:0] xf_s  [0:N];
	logic signed [AXW-1:0] yf_s  [0:N];
	logic signed [ZW-1:0]  zf_s  [0:N];
	logic signed [AXW-1:0] xr_s  [0:N];
	logic signed [AXW-1:0] yr_s  [0:N];
	logic signed [ZW-1:0]  zr_s  [0:N];
	logic signed [SCW-1:0] xc_s  [0:N];
	logic signed [SCW-1:0] yc_s  [0:N];
	logic signed [ACW-1:0] ac_s  [0:N];
	side_t                 side_s[0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s[0] <= 1'b0;
		end else begin
			val_s[0] <= val_s1;
		end
	end

	always_ff @(posedge clk) begin
		xf_s[0] <= vx_c;
		yf_s[0] <= yf_c;
		zf_s[0] <= '0;
		xr_s[0] <= vx_c;
		yr_s[0] <= yr_c;
		zr_s[0] <= '0;
		xc_s[0] <= GAIN_INV;
		yc_s[0] <= '0;
		ac_s[0] <= a2_c;
		side_s[0] <= side_c;
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		localparam logic signed [ZW-1:0] TZ = $signed(ZW'(ATAN_TABLE[i]));
		localparam logic signed [ACW-1:0] TA = $signed(ACW'(ATAN_TABLE[i]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_s[i+1] <= 1'b0;
			end else begin
				val_s[i+1] <= val_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (!yf_s[i][AXW-1]) begin
				xf_s[i+1] <= xf_s[i] + (yf_s[i] >>> i);
				yf_s[i+1] <= yf_s[i] - (xf_s[i] >>> i);
				zf_s[i+1] <= zf_s[i] + TZ;
			end else begin
				xf_s[i+1] <= xf_s[i] - (yf_s[i] >>> i);
				yf_s[i+1] <= yf_s[i] + (xf_s[i] >>> i);
				zf_s[i+1] <= zf_s[i] - TZ;
			end
			if (!yr_s[i][AXW-1]) begin
				xr_s[i+1] <= xr_s[i] + (yr_s[i] >>> i);
				yr_s[i+1] <= yr_s[i] - (xr_s[i] >>> i);
				zr_s[i+1] <= zr_s[i] + TZ;
			end else begin
				xr_s[i+1] <= xr_s[i] - (yr_s[i] >>> i);
				yr_s[i+1] <= yr_s[i] + (xr_s[i] >>> i);
				zr_s[i+1] <= zr_s[i] - TZ;
			end
			if (!ac_s[i][ACW-1]) begin
				xc_s[i+1] <= xc_s[i] - (yc_s[i] >>> i);
				yc_s[i+1] <= yc_s[i] + (xc_s[i] >>> i);
				ac_s[i+1] <= ac_s[i] - TA;
			end else begin
				xc_s[i+1] <= xc_s[i] + (yc_s[i] >>> i);
				yc_s[i+1] <= yc_s[i] - (xc_s[i] >>> i);
				ac_s[i+1] <= ac_s[i] + TA;
			end
			side_s[i+1] <= side_s[i];
		end
	end

	// Round the angles to Q3.12 and apply the quadrant flip.
	logic signed [TW-1:0]  tf_c, tr_c;
	logic                  val_s3;
	logic signed [15:0]    fsa_s3, rsa_s3;
	logic signed [SCW-1:0] cos_s3, sin_s3;
	side_t                 side_s3;

	assign tf_c = TW'(zf_s[N]) - (TW'(side_s[N].steer) <<< 8) + 27'sd128;
	assign tr_c = TW'(zr_s[N]) + 27'sd128;

	always_ff @(posedge clk) begin
		fsa_s3 <= sat16(24'(tf_c >>> 8));
		rsa_s3 <= sat16(24'(tr_c >>> 8));
		cos_s3 <= side_s[N].flip ? -xc_s[N] : xc_s[N];
		sin_s3 <= side_s[N].flip ? -yc_s[N] : yc_s[N];
		side_s3 <= side_s[N];
	end

	// Products for the front axle speed; a*yaw*sin is split in two halves.
	logic               val_s4;
	logic signed [43:0] pv_s4;
	logic signed [46:0] ph_s4;
	logic signed [47:0] pl_s4;
	logic signed [15:0] fsa_s4, rsa_s4;
	side_t              side_s4;

	always_ff @(posedge clk) begin
		pv_s4 <= side_s3.speed * cos_s3;
		ph_s4 <= side_s3.ayaw * $signed(sin_s3[SCW-1:SPLIT]);
		pl_s4 <= side_s3.ayaw * $signed({1'b0, sin_s3[SPLIT-1:0]});
		fsa_s4 <= fsa_s3;
		rsa_s4 <= rsa_s3;
		side_s4 <= side_s3;
	end

	// Front axle speed at scale 2^16.
	logic signed [60:0]       sum_c;
	logic                     val_s5;
	logic signed [DIV_DW-1:0] fa_s5;
	logic signed [15:0]       fsa_s5, rsa_s5;
	side_t                    side_s5;

	assign sum_c = (61'(ph_s4) <<< SPLIT) + 61'(pl_s4);

	always_ff @(posedge clk) begin
		fa_s5 <= DIV_DW'(pv_s4 >>> 16) + DIV_DW'(sum_c >>> 32);
		fsa_s5 <= fsa_s4;
		rsa_s5 <= rsa_s4;
		side_s5 <= side_s4;
	end

	// Divider operands.
	logic                     val_s6, low_s6;
	logic signed [DIV_NW-1:0] numf_s6, numr_s6;
	logic signed [DIV_DW-1:0] denf_s6, denr_s6;
	logic signed [15:0]       fsa_s6, rsa_s6;

	always_ff @(posedge clk) begin
		numf_s6 <= DIV_NW'(fa_s5) - (DIV_NW'(side_s5.wf) <<< 8);
		denf_s6 <= fa_s5;
		numr_s6 <= DIV_NW'(side_s5.speed) - DIV_NW'(side_s5.wr);
		denr_s6 <= DIV_DW'(side_s5.speed);
		fsa_s6 <= fsa_s5;
		rsa_s6 <= rsa_s5;
		low_s6 <= side_s5.low;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s3 <= 1'b0;
			val_s4 <= 1'b0;
			val_s5 <= 1'b0;
			val_s6 <= 1'b0;
		end else begin
			val_s3 <= val_s[N];
			val_s4 <= val_s3;
			val_s5 <= val_s4;
			val_s6 <= val_s5;
		end
	end

	logic signed [15:0] fr_c, rr_c;

	tsar_div u_div_front (
		.clk  (clk),
		.num  (numf_s6),
		.den  (denf_s6),
		.ratio(fr_c)
	);

	tsar_div u_div_rear (
		.clk  (clk),
		.num  (numr_s6),
		.den  (denr_s6),
		.ratio(rr_c)
	);

	// Angles and flags wait alongside the dividers.
	logic               val_dl[0:DIV_LAT-1];
	logic               low_dl[0:DIV_LAT-1];
	logic signed [15:0] fsa_dl[0:DIV_LAT-1];
	logic signed [15:0] rsa_dl[0:DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) begin
				val_dl[k] <= 1'b0;
			end
		end else begin
			val_dl[0] <= val_s6;
			for (int k = 1; k < DIV_LAT; k++) begin
				val_dl[k] <= val_dl[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		low_dl[0] <= low_s6;
		fsa_dl[0] <= fsa_s6;
		rsa_dl[0] <= rsa_s6;
		for (int k = 1; k < DIV_LAT; k++) begin
			low_dl[k] <= low_dl[k-1];
			fsa_dl[k] <= fsa_dl[k-1];
			rsa_dl[k] <= rsa_dl[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= val_dl[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (low_dl[DIV_LAT-1]) begin
			result <= '0;
		end else begin
			result.front_slip_angle <= fsa_dl[DIV_LAT-1];
			result.rear_slip_angle <= rsa_dl[DIV_LAT-1];
			result.front_slip_ratio <= fr_c;
			result.rear_slip_ratio <= rr_c;
		end
	end

endmodule

// File: rtl/tsar_chk.sv
// ----------------------------------------------------------------------------
// tsar_chk: port-level checks for the tire slip angle and ratio block
// Fixed latency between accepted samples and results, and the low-speed rule.
// ----------------------------------------------------------------------------
module tsar_chk
	import tsar_pkg::*;
#(
	parameter int CORDIC_STAGES = 14
) (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input sample_t sample,
	input logic    done,
	input result_t result
);

	localparam int LAT = CORDIC_STAGES + LAT_FIXED;

	logic accepted;
	assign accepted = start && !busy;

	// Every accepted sample yields exactly one result after the fixed latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accepted |-> ##LAT done)
		else $error("no result after an accepted sample");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accepted, LAT))
		else $error("result without a matching sample");

	// At or below 1 m/s the whole result transaction is zero.
	a_low_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(accepted && (sample.body_speed <= LOW_SPEED)) |-> ##LAT (result == '0))
		else $error("nonzero result for a low-speed sample");

endmodule

bind tire_slip_angle_and_ratio tsar_chk #(
	.CORDIC_STAGES(CORDIC_STAGES)
) u_tsar_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.sample(sample),
	.done  (done),
	.result(result)
);
